[src/cor_pkg.sv]
// Shared types and constants of the circle outline rasteriser.
`default_nettype none

package cor_pkg;

	localparam logic OP_START = 1'b0;
	localparam logic OP_NEXT  = 1'b1;

	localparam logic [2:0] OCT_LAST = 3'd7;

	localparam logic [15:0] DEC_INIT     = 16'd3;
	localparam logic [15:0] DEC_STEP_NEG = 16'd6;
	localparam logic [15:0] DEC_STEP_POS = 16'd10;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic        is_start;
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [7:0]  radius;
		logic [15:0] color;
	} cmd_t;

endpackage

`default_nettype wire

[src/cor_front.sv]
// Input side: decodes each item and holds it in a two-entry command queue.
`default_nettype none

module cor_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire logic          opcode,
	input  wire logic [15:0]   center_x,
	input  wire logic [15:0]   center_y,
	input  wire logic [7:0]    radius,
	input  wire logic [15:0]   color,
	output      logic          cmd_valid,
	input  wire logic          cmd_ready,
	output      cor_pkg::cmd_t cmd
);

	cor_pkg::cmd_t mem_q [cor_pkg::QUEUE_DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;
	cor_pkg::cmd_t cmd_in;

	always_comb begin
		cmd_in.is_start = (opcode == cor_pkg::OP_START);
		cmd_in.center_x = center_x;
		cmd_in.center_y = center_y;
		cmd_in.radius   = radius;
		cmd_in.color    = color;
	end

	assign in_ready  = (count_q != 2'(cor_pkg::QUEUE_DEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

[src/cor_back.sv]
// Execution side: circle stepping state, point generation and output register.
`default_nettype none

module cor_back #(
	parameter int unsigned COLOR_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output      logic          cmd_ready,
	input  wire cor_pkg::cmd_t cmd,
	output      logic          out_valid,
	input  wire logic          out_ready,
	output      logic [15:0]   pixel_x,
	output      logic [15:0]   pixel_y,
	output      logic [15:0]   pixel_color,
	output      logic          last_pixel
);

	localparam logic [15:0] COLOR_MASK =
		(COLOR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COLOR_BITS) - 32'd1);

	logic              busy_q;
	logic [2:0]        oct_q;
	logic [7:0]        step_a_q;
	logic signed [8:0] step_b_q;
	logic [15:0]       decision_q;
	logic [15:0]       cx_q;
	logic [15:0]       cy_q;
	logic [15:0]       colour_q;

	logic              out_valid_q;
	logic [15:0]       px_q;
	logic [15:0]       py_q;
	logic [15:0]       pc_q;
	logic              last_q;

	logic              can_out;
	logic              emit;
	logic [15:0]       a16;
	logic [15:0]       b16;
	logic [15:0]       dx;
	logic [15:0]       dy;
	logic [7:0]        a_nxt;
	logic signed [8:0] b_nxt;
	logic signed [9:0] diff;
	logic [15:0]       dec_nxt;
	logic              last_nxt;

	assign can_out   = !out_valid_q || out_ready;
	assign cmd_ready = cmd.is_start || !busy_q || can_out;
	assign emit      = cmd_valid && cmd_ready && !cmd.is_start && busy_q;

	assign a16 = {8'd0, step_a_q};
	assign b16 = {{7{step_b_q[8]}}, step_b_q};

	always_comb begin
		unique case (oct_q)
			3'd0: begin dx = a16;              dy = 16'd0 - b16; end
			3'd1: begin dx = b16;              dy = 16'd0 - a16; end
			3'd2: begin dx = b16;              dy = a16;         end
			3'd3: begin dx = a16;              dy = b16;         end
			3'd4: begin dx = 16'd0 - a16;      dy = b16;         end
			3'd5: begin dx = 16'd0 - b16;      dy = a16;         end
			3'd6: begin dx = 16'd0 - a16;      dy = 16'd0 - b16; end
			default: begin dx = 16'd0 - b16;   dy = 16'd0 - a16; end
		endcase
	end

	always_comb begin
		a_nxt = step_a_q + 8'd1;
		diff  = $signed({2'b00, a_nxt}) - $signed({step_b_q[8], step_b_q});
		if (decision_q[15]) begin
			dec_nxt = decision_q + {6'd0, a_nxt, 2'b00} + cor_pkg::DEC_STEP_NEG;
			b_nxt   = step_b_q;
		end else begin
			dec_nxt = decision_q + cor_pkg::DEC_STEP_POS
				+ {{4{diff[9]}}, diff, 2'b00};
			b_nxt   = step_b_q - 9'sd1;
		end
		last_nxt = (oct_q == cor_pkg::OCT_LAST)
			&& ($signed({2'b00, a_nxt}) > $signed({b_nxt[8], b_nxt}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			oct_q      <= 3'd0;
			step_a_q   <= 8'd0;
			step_b_q   <= 9'sd0;
			decision_q <= 16'd0;
			cx_q       <= 16'd0;
			cy_q       <= 16'd0;
			colour_q   <= 16'd0;
		end else if (cmd_valid && cmd_ready) begin
			if (cmd.is_start) begin
				busy_q     <= 1'b1;
				oct_q      <= 3'd0;
				step_a_q   <= 8'd0;
				step_b_q   <= $signed({1'b0, cmd.radius});
				decision_q <= cor_pkg::DEC_INIT - {7'd0, cmd.radius, 1'b0};
				cx_q       <= cmd.center_x;
				cy_q       <= cmd.center_y;
				colour_q   <= cmd.color & COLOR_MASK;
			end else if (busy_q) begin
				if (oct_q == cor_pkg::OCT_LAST) begin
					oct_q      <= 3'd0;
					step_a_q   <= a_nxt;
					step_b_q   <= b_nxt;
					decision_q <= dec_nxt;
					if (last_nxt) busy_q <= 1'b0;
				end else begin
					oct_q <= oct_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			px_q   <= cx_q + dx;
			py_q   <= cy_q + dy;
			pc_q   <= colour_q;
			last_q <= last_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_color = pc_q;
	assign last_pixel  = last_q;

	// While a circle runs the column offset never passes the row offset.
	a_le_b: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ($signed({2'b00, step_a_q}) <= $signed({step_b_q[8], step_b_q})))
		else $error("step a exceeds step b while busy");

	idle_oct_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (oct_q == 3'd0))
		else $error("octant index not cleared while idle");

	last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_nxt) |=> (!busy_q && last_q && out_valid_q))
		else $error("final point did not end the circle");

	emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> can_out)
		else $error("point generated while output register full");

endmodule

`default_nettype wire

[src/circle_outline_rasterizer.sv]
// Top level of the midpoint circle outline rasteriser.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | opcode, center_x, center_y, radius, color
//  output  | out_valid / out_ready| pixel_x, pixel_y, pixel_color, last_pixel
//
// One item is taken per cycle while the queue has room; a next item of a running
// circle gives its pixel in the cycle after it leaves the two-entry command queue.
// The back end gives one pixel per clock while the output is not stalled, as the
// point and the next decision are computed combinationally. A start item passes
// through and gives no transfer. Reset is asynchronous and leaves the block idle.
// A stalled output holds the back end, and the queue absorbs two items.
`default_nettype none

module circle_outline_rasterizer #(
	parameter int unsigned COLOR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        opcode,
	input  wire logic [15:0] center_x,
	input  wire logic [15:0] center_y,
	input  wire logic [7:0]  radius,
	input  wire logic [15:0] color,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [15:0] pixel_x,
	output      logic [15:0] pixel_y,
	output      logic [15:0] pixel_color,
	output      logic        last_pixel
);

	logic          cmd_valid;
	logic          cmd_ready;
	cor_pkg::cmd_t cmd;

	cor_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.color     (color),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	cor_back #(
		.COLOR_BITS (COLOR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule

`default_nettype wire

[test/circle_outline_rasterizer_checker.sv]
// Checker for the circle outline rasteriser: predicts each pixel and compares results.
`timescale 1ns / 1ps

module circle_outline_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        opcode,
	input  wire logic [15:0] center_x,
	input  wire logic [15:0] center_y,
	input  wire logic [7:0]  radius,
	input  wire logic [15:0] color,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [15:0] pixel_x,
	input  wire logic [15:0] pixel_y,
	input  wire logic [15:0] pixel_color,
	input  wire logic        last_pixel,
	output int               outstanding,
	output int               fail_count
);

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] colour;
		logic        last;
	} pixel_t;

	pixel_t pending_pixels[$];

	logic               drawing;
	logic [2:0]         octant;
	logic [7:0]         step_a;
	logic signed [8:0]  step_b;
	logic signed [15:0] decision;
	logic [15:0]        centre_x;
	logic [15:0]        centre_y;
	logic [15:0]        colour;

	task automatic trace_outline(input logic op, input logic [15:0] cx, input logic [15:0] cy,
			input logic [7:0] r, input logic [15:0] c);
		logic [15:0] a16;
		logic [15:0] b16;
		logic [15:0] dx;
		logic [15:0] dy;
		int          d;
		pixel_t      p;
		if (op == cor_pkg::OP_START) begin
			centre_x = cx;
			centre_y = cy;
			colour   = c;
			step_a   = '0;
			step_b   = 9'(r);
			d        = int'(cor_pkg::DEC_INIT) - 2 * int'(r);
			decision = d[15:0];
			octant   = '0;
			drawing  = 1'b1;
		end else if (drawing) begin
			a16 = 16'(step_a);
			b16 = {7'd0, step_b};
			case (octant)
				3'd0: begin dx = a16;  dy = -b16; end
				3'd1: begin dx = b16;  dy = -a16; end
				3'd2: begin dx = b16;  dy = a16;  end
				3'd3: begin dx = a16;  dy = b16;  end
				3'd4: begin dx = -a16; dy = b16;  end
				3'd5: begin dx = -b16; dy = a16;  end
				3'd6: begin dx = -a16; dy = -b16; end
				default: begin dx = -b16; dy = -a16; end
			endcase
			p.x      = centre_x + dx;
			p.y      = centre_y + dy;
			p.colour = colour;
			p.last   = 1'b0;
			if (octant == cor_pkg::OCT_LAST) begin
				octant = '0;
				step_a = step_a + 8'd1;
				if (decision < 0) begin
					d = int'(decision) + 4 * int'(step_a) + int'(cor_pkg::DEC_STEP_NEG);
				end else begin
					d = int'(decision) + int'(cor_pkg::DEC_STEP_POS)
						+ 4 * (int'(step_a) - int'(step_b));
					step_b = step_b - 9'sd1;
				end
				decision = d[15:0];
				if (int'(step_a) > int'(step_b)) begin
					p.last  = 1'b1;
					drawing = 1'b0;
				end
			end else begin
				octant = octant + 3'd1;
			end
			pending_pixels.push_back(p);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			drawing  = 1'b0;
			octant   = '0;
			step_a   = '0;
			step_b   = '0;
			decision = '0;
			centre_x = '0;
			centre_y = '0;
			colour   = '0;
			pending_pixels.delete();
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				trace_outline(opcode, center_x, center_y, radius, color);
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: unexpected pixel transfer, expected none, actual (%h, %h) %h %b",
						$time, pixel_x, pixel_y, pixel_color, last_pixel);
					fail_count++;
				end else begin
					want = pending_pixels.pop_front();
					check_field("pixel_x", want.x, pixel_x);
					check_field("pixel_y", want.y, pixel_y);
					check_field("pixel_color", want.colour, pixel_color);
					check_field("last_pixel", 16'(want.last), 16'(last_pixel));
				end
			end
			outstanding <= pending_pixels.size();
		end
	end

endmodule

[test/circle_outline_rasterizer_tb.sv]
// Testbench top for the circle outline rasteriser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module circle_outline_rasterizer_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = cor_pkg::OP_NEXT;
	logic [15:0] center_x = '0;
	logic [15:0] center_y = '0;
	logic [7:0]  radius = '0;
	logic [15:0] color = '0;
	logic        out_valid;
	logic        out_ready = 1'b1;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic [15:0] pixel_color;
	logic        last_pixel;
	int          outstanding;
	int          fail_count;

	logic        calm = 1'b0;
	int unsigned gap_pct = 30;
	int unsigned stall_pct = 30;
	int unsigned ready_hold = 0;

	always #4 clk = ~clk;

	circle_outline_rasterizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .center_x(center_x), .center_y(center_y),
		.radius(radius), .color(color),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
		.last_pixel(last_pixel)
	);

	circle_outline_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .center_x(center_x), .center_y(center_y),
		.radius(radius), .color(color),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
		.last_pixel(last_pixel),
		.outstanding(outstanding), .fail_count(fail_count)
	);

	// The receiver stalls in short bursts, never in the final stretch.
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_ready  <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
			ready_hold <= $urandom_range(0, 2);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Entered and left at a falling edge; returns once the transfer has happened.
	task automatic send_item(input logic op, input logic [15:0] cx, input logic [15:0] cy,
			input logic [7:0] r, input logic [15:0] c);
		int unsigned pause;
		pause = 0;
		if (!calm && $urandom_range(0, 99) < gap_pct)
			pause = $urandom_range(1, 3);
		if (pause != 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		center_x <= cx;
		center_y <= cy;
		radius   <= r;
		color    <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_next(input int unsigned count);
		repeat (count)
			send_item(cor_pkg::OP_NEXT, 16'($urandom), 16'($urandom), 8'($urandom),
				16'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned r;
		int unsigned full;
		int unsigned n;
		sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_next(1);
		send_item(cor_pkg::OP_START, 16'h0000, 16'h0000, 8'd0, 16'hFFFF);
		send_next(8);
		send_next(1);
		send_item(cor_pkg::OP_START, 16'hFFFF, 16'hFFFF, 8'd1, 16'h0000);
		send_next(8);
		send_item(cor_pkg::OP_START, 16'h8000, 16'h7FFF, 8'd255, 16'hA5A5);
		send_next(3);
		send_item(cor_pkg::OP_START, 16'h0001, 16'hFFFE, 8'd2, 16'h5A5A);
		drain();

		while (sent < 400) begin
			calm = (sent > 320);
			gap_pct   = calm ? 0 : ($urandom_range(0, 2) * 25);
			stall_pct = calm ? 0 : ($urandom_range(0, 2) * 25);
			if ($urandom_range(0, 5) == 0)
				drain();
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 3);
				send_next(n);
				sent += n;
			end
			r = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			full = 8 * ((r * 181) / 256 + 1);
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(0, full);
			else
				n = 8 * ((r * 3) / 4 + 2) + $urandom_range(0, 2);
			if (sent + n > 399)
				n = (sent < 399) ? 399 - sent : 0;
			send_item(cor_pkg::OP_START, 16'($urandom), 16'($urandom), 8'(r), 16'($urandom));
			send_next(n);
			sent += 1 + n;
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
